>>> rtl/soc_pkg.sv
package soc_pkg;

    // Store sizes
    localparam int QUAD_SLOTS   = 8;
    localparam int CIRCLE_SLOTS = 4;

    // Derived widths
    localparam int QA_W = $clog2(QUAD_SLOTS * 4);     // corner memory address
    localparam int QN_W = $clog2(QUAD_SLOTS + 1);     // quad count
    localparam int EK_W = QN_W + 2;                   // edge count
    localparam int CI_W = $clog2(CIRCLE_SLOTS);       // circle index
    localparam int CN_W = $clog2(CIRCLE_SLOTS + 1);   // circle count

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FP_W       = $clog2(FIFO_DEPTH);
    localparam int FC_W       = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes
    localparam logic [1:0] CFG_ACTIVE_QUADS   = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_CIRCLES = 2'd1;

    typedef enum logic [1:0] {
        CMD_QUAD   = 2'd0,
        CMD_CIRCLE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // One queued word
    typedef struct packed {
        t_cmd               cmd;
        logic [2:0]         slot;
        logic [1:0]         corner;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic [14:0]        radius;
    } t_word;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EDGE,
        BK_DRAIN,
        BK_CIRC,
        BK_DONE
    } t_bstate;

    // Circle test sequence steps
    typedef enum logic [3:0] {
        CS_LOAD, CS_M1, CS_M2, CS_M3, CS_M4, CS_M5,
        CS_M6, CS_M7, CS_M8, CS_M9, CS_EVAL
    } t_cstep;

endpackage

>>> rtl/soc_front.sv
module soc_front (
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_command,
    input  logic [2:0]             i_slot,
    input  logic [1:0]             i_corner,
    input  logic signed [15:0]     i_point_x,
    input  logic signed [15:0]     i_point_y,
    input  logic signed [15:0]     i_end_x,
    input  logic signed [15:0]     i_end_y,
    input  logic [14:0]            i_radius,
    input  soc_pkg::t_qstat        i_qstat,
    output logic                   o_push,
    output soc_pkg::t_word         o_word
);

    logic keep;

    // Drop unused commands and writes beyond the stores
    always_comb begin
        case (soc_pkg::t_cmd'(i_command))
            soc_pkg::CMD_QUAD:   keep = (int'(i_slot) < soc_pkg::QUAD_SLOTS);
            soc_pkg::CMD_CIRCLE: keep = (int'(i_slot) < soc_pkg::CIRCLE_SLOTS);
            soc_pkg::CMD_QUERY:  keep = 1'b1;
            default:             keep = 1'b0;
        endcase
    end

    assign o_stall = i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full && keep;

    always_comb begin
        o_word.cmd    = soc_pkg::t_cmd'(i_command);
        o_word.slot   = i_slot;
        o_word.corner = i_corner;
        o_word.px     = i_point_x;
        o_word.py     = i_point_y;
        o_word.ex     = i_end_x;
        o_word.ey     = i_end_y;
        o_word.radius = i_radius;
    end

endmodule

>>> rtl/soc_fifo.sv
module soc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  soc_pkg::t_word  i_word,
    input  logic            i_pop,
    output soc_pkg::t_word  o_word,
    output soc_pkg::t_qstat o_qstat
);

    soc_pkg::t_word              r_buf [soc_pkg::FIFO_DEPTH];
    logic [soc_pkg::FP_W-1:0]    r_wp, r_rp;
    logic [soc_pkg::FC_W-1:0]    r_cnt;
    logic                        do_push, do_pop;

    assign o_qstat.full  = (int'(r_cnt) == soc_pkg::FIFO_DEPTH);
    assign o_qstat.empty = (r_cnt == '0);
    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;
    assign o_word  = r_buf[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Payload storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_buf[r_wp] <= i_word;
    end

endmodule

>>> rtl/soc_back.sv
module soc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  soc_pkg::t_qstat i_qstat,
    input  soc_pkg::t_word  i_word,
    output logic            o_pop,
    input  logic [3:0]      i_active_quads,
    input  logic [2:0]      i_active_circles,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_safe
);

    localparam int QDEPTH = soc_pkg::QUAD_SLOTS * 4;
    localparam int CN_EXT = soc_pkg::CN_W + 1;

    soc_pkg::t_bstate r_state, n_state;
    soc_pkg::t_cstep  r_cs;

    // Active counts, clamped to the stores
    logic [soc_pkg::QN_W-1:0] nq;
    logic [soc_pkg::CN_W-1:0] nc;
    logic [soc_pkg::EK_W-1:0] n_edges;

    assign nq = (int'(i_active_quads) > soc_pkg::QUAD_SLOTS) ?
                soc_pkg::QN_W'(soc_pkg::QUAD_SLOTS) : soc_pkg::QN_W'(i_active_quads);
    assign nc = (int'(i_active_circles) > soc_pkg::CIRCLE_SLOTS) ?
                soc_pkg::CN_W'(soc_pkg::CIRCLE_SLOTS) : soc_pkg::CN_W'(i_active_circles);
    assign n_edges = {nq, 2'b00};

    // Query segment
    logic signed [15:0] r_ax, r_ay, r_bx, r_by;
    logic signed [16:0] r_ux, r_uy;
    logic               r_hit;
    logic               r_out_valid, r_safe;

    // Edge pipeline
    logic [soc_pkg::EK_W-1:0] r_k;
    logic [31:0]              r_mem [QDEPTH];
    logic [31:0]              r_ca, r_cb;
    logic                     r_v1, r_v2, r_v3, r_v4;
    logic signed [16:0]       r_vx, r_vy, r_qx, r_qy;
    logic signed [33:0]       r_e0, r_e1, r_e2, r_e3, r_e4, r_e5;
    logic signed [34:0]       r_det, r_ns, r_nt;
    logic [soc_pkg::QA_W-1:0] ra_a, ra_b, wa;
    logic signed [15:0]       c_x, c_y, e_x, e_y;
    logic signed [34:0]       det_a, ns_a, nt_a;
    logic                     edge_hit;

    // Circle store and test unit
    logic signed [15:0]       r_cx [soc_pkg::CIRCLE_SLOTS];
    logic signed [15:0]       r_cy [soc_pkg::CIRCLE_SLOTS];
    logic [14:0]              r_cr_rad [soc_pkg::CIRCLE_SLOTS];
    logic [soc_pkg::CI_W-1:0] r_ci;
    logic signed [16:0]       r_wx, r_wy, r_fx, r_fy;
    logic [14:0]              r_rad;
    logic signed [49:0]       r_p0, r_p1;
    logic signed [30:0]       ma0, ma1;
    logic signed [18:0]       mb0, mb1;
    logic signed [35:0]       r_dot, r_w2, r_f2, r_crs;
    logic [33:0]              r_len2;
    logic [29:0]              r_r2;
    logic [69:0]              r_big1, r_big2;
    logic [35:0]              acr;
    logic [17:0]              hi;
    logic [16:0]              lo;
    logic signed [35:0]       r2_s, len2_s;
    logic                     circ_hit, circ_last;

    logic issue, out_load, q_pop;

    // Control: next state
    always_comb begin
        n_state  = r_state;
        q_pop    = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            soc_pkg::BK_IDLE: begin
                if (!i_qstat.empty) begin
                    q_pop = 1'b1;
                    if (i_word.cmd == soc_pkg::CMD_QUERY) n_state = soc_pkg::BK_EDGE;
                end
            end
            soc_pkg::BK_EDGE: begin
                if (r_k < n_edges) issue = 1'b1;
                else n_state = soc_pkg::BK_DRAIN;
            end
            soc_pkg::BK_DRAIN: begin
                if (!(r_v1 || r_v2 || r_v3 || r_v4))
                    n_state = (nc != '0) ? soc_pkg::BK_CIRC : soc_pkg::BK_DONE;
            end
            soc_pkg::BK_CIRC: begin
                if (r_cs == soc_pkg::CS_EVAL && circ_last) n_state = soc_pkg::BK_DONE;
            end
            soc_pkg::BK_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = soc_pkg::BK_IDLE;
                end
            end
            default: n_state = soc_pkg::BK_IDLE;
        endcase
    end

    assign o_pop     = q_pop;
    assign circ_last = !((CN_EXT'(r_ci) + 1'b1) < CN_EXT'(nc));

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= soc_pkg::BK_IDLE;
            r_cs        <= soc_pkg::CS_LOAD;
            r_ci        <= '0;
            r_k         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            if (issue) r_k <= r_k + 1'b1;
            if (q_pop && i_word.cmd == soc_pkg::CMD_QUERY) begin
                r_k   <= '0;
                r_hit <= 1'b0;
            end
            if (r_v4 && edge_hit) r_hit <= 1'b1;
            if (r_state == soc_pkg::BK_DRAIN) begin
                r_cs <= soc_pkg::CS_LOAD;
                r_ci <= '0;
            end else if (r_state == soc_pkg::BK_CIRC) begin
                if (r_cs == soc_pkg::CS_EVAL) begin
                    r_cs <= soc_pkg::CS_LOAD;
                    r_ci <= r_ci + 1'b1;
                    if (circ_hit) r_hit <= 1'b1;
                end else begin
                    r_cs <= soc_pkg::t_cstep'(r_cs + 1'b1);
                end
            end
            if (out_load) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (out_load) r_safe <= !r_hit;
    end
    assign o_valid = r_out_valid;
    assign o_safe  = r_safe;

    // Query latch and circle writes
    always_ff @(posedge i_clk) begin
        if (q_pop && i_word.cmd == soc_pkg::CMD_QUERY) begin
            r_ax <= i_word.px;
            r_ay <= i_word.py;
            r_bx <= i_word.ex;
            r_by <= i_word.ey;
            r_ux <= 17'(i_word.ex) - 17'(i_word.px);
            r_uy <= 17'(i_word.ey) - 17'(i_word.py);
        end
        if (q_pop && i_word.cmd == soc_pkg::CMD_CIRCLE) begin
            r_cx[i_word.slot[soc_pkg::CI_W-1:0]]     <= i_word.px;
            r_cy[i_word.slot[soc_pkg::CI_W-1:0]]     <= i_word.py;
            r_cr_rad[i_word.slot[soc_pkg::CI_W-1:0]] <= i_word.radius;
        end
    end

    // Corner memory: one write port, two registered read ports
    assign wa   = {i_word.slot[soc_pkg::QA_W-3:0], i_word.corner};
    assign ra_a = r_k[soc_pkg::QA_W-1:0];
    assign ra_b = {r_k[soc_pkg::QA_W-1:2], r_k[1:0] + 2'd1};

    always_ff @(posedge i_clk) begin
        if (q_pop && i_word.cmd == soc_pkg::CMD_QUAD) r_mem[wa] <= {i_word.px, i_word.py};
        r_ca <= r_mem[ra_a];
        r_cb <= r_mem[ra_b];
    end

    assign c_x = r_ca[31:16];
    assign c_y = r_ca[15:0];
    assign e_x = r_cb[31:16];
    assign e_y = r_cb[15:0];

    // Edge stages: differences, products, determinants
    always_ff @(posedge i_clk) begin
        r_vx  <= 17'(e_x) - 17'(c_x);
        r_vy  <= 17'(e_y) - 17'(c_y);
        r_qx  <= 17'(r_ax) - 17'(c_x);
        r_qy  <= 17'(r_ay) - 17'(c_y);
        r_e0  <= r_vx * r_uy;
        r_e1  <= r_ux * r_vy;
        r_e2  <= r_qx * r_uy;
        r_e3  <= r_qy * r_ux;
        r_e4  <= r_qx * r_vy;
        r_e5  <= r_qy * r_vx;
        r_det <= 35'(r_e0) - 35'(r_e1);
        r_ns  <= 35'(r_e2) - 35'(r_e3);
        r_nt  <= 35'(r_e4) - 35'(r_e5);
    end

    // Inclusive range test, parallel edges never hit
    always_comb begin
        det_a = r_det[34] ? -r_det : r_det;
        ns_a  = r_det[34] ? -r_ns  : r_ns;
        nt_a  = r_det[34] ? -r_nt  : r_nt;
        edge_hit = (r_det != '0) && (ns_a >= 0) && (ns_a <= det_a) &&
                   (nt_a >= 0) && (nt_a <= det_a);
    end

    // Circle unit: two shared multipliers, one step per cycle
    assign acr = r_crs[35] ? 36'(-r_crs) : 36'(r_crs);
    assign hi  = acr[34:17];
    assign lo  = acr[16:0];

    always_comb begin
        ma0 = '0;
        mb0 = '0;
        ma1 = '0;
        mb1 = '0;
        case (r_cs)
            soc_pkg::CS_M1: begin
                ma0 = 31'(r_wx); mb0 = 19'(r_ux); ma1 = 31'(r_wy); mb1 = 19'(r_uy);
            end
            soc_pkg::CS_M2: begin
                ma0 = 31'(r_wx); mb0 = 19'(r_wx); ma1 = 31'(r_wy); mb1 = 19'(r_wy);
            end
            soc_pkg::CS_M3: begin
                ma0 = 31'(r_fx); mb0 = 19'(r_fx); ma1 = 31'(r_fy); mb1 = 19'(r_fy);
            end
            soc_pkg::CS_M4: begin
                ma0 = 31'(r_wx); mb0 = 19'(r_uy); ma1 = 31'(r_wy); mb1 = 19'(r_ux);
            end
            soc_pkg::CS_M5: begin
                ma0 = 31'(r_ux); mb0 = 19'(r_ux); ma1 = 31'(r_uy); mb1 = 19'(r_uy);
            end
            soc_pkg::CS_M6: begin
                ma0 = $signed({16'd0, r_rad}); mb0 = $signed({4'd0, r_rad});
                ma1 = $signed({13'd0, hi});    mb1 = $signed({1'b0, hi});
            end
            soc_pkg::CS_M7: begin
                ma0 = $signed({13'd0, hi}); mb0 = $signed({2'd0, lo});
                ma1 = $signed({14'd0, lo}); mb1 = $signed({2'd0, lo});
            end
            soc_pkg::CS_M8: begin
                ma0 = $signed({1'b0, r_r2}); mb0 = $signed({2'd0, r_len2[33:17]});
                ma1 = $signed({1'b0, r_r2}); mb1 = $signed({2'd0, r_len2[16:0]});
            end
            default: begin
                ma0 = '0;
            end
        endcase
    end

    // Circle datapath registers
    always_ff @(posedge i_clk) begin
        r_p0 <= ma0 * mb0;
        r_p1 <= ma1 * mb1;
        case (r_cs)
            soc_pkg::CS_LOAD: begin
                r_wx  <= 17'(r_cx[r_ci]) - 17'(r_ax);
                r_wy  <= 17'(r_cy[r_ci]) - 17'(r_ay);
                r_fx  <= 17'(r_cx[r_ci]) - 17'(r_bx);
                r_fy  <= 17'(r_cy[r_ci]) - 17'(r_by);
                r_rad <= r_cr_rad[r_ci];
            end
            soc_pkg::CS_M2: r_dot  <= 36'(r_p0) + 36'(r_p1);
            soc_pkg::CS_M3: r_w2   <= 36'(r_p0) + 36'(r_p1);
            soc_pkg::CS_M4: r_f2   <= 36'(r_p0) + 36'(r_p1);
            soc_pkg::CS_M5: r_crs  <= 36'(r_p0) - 36'(r_p1);
            soc_pkg::CS_M6: r_len2 <= r_p0[33:0] + r_p1[33:0];
            soc_pkg::CS_M7: begin
                r_r2   <= r_p0[29:0];
                r_big1 <= 70'(r_p1[35:0]) << 34;
            end
            soc_pkg::CS_M8: r_big1 <= r_big1 + (70'(r_p0[35:0]) << 18) + 70'(r_p1[33:0]);
            soc_pkg::CS_M9: r_big2 <= (70'(r_p0[46:0]) << 17) + 70'(r_p1[46:0]);
            default: begin
                r_big2 <= r_big2;
            end
        endcase
    end

    // Closest point: before start, past end, or on the segment; a zero-length query segment never hits
    assign r2_s   = $signed({6'd0, r_r2});
    assign len2_s = $signed({2'd0, r_len2});

    always_comb begin
        if (r_ux == '0 && r_uy == '0) circ_hit = 1'b0;
        else if (r_dot < 0)           circ_hit = (r_w2 <= r2_s);
        else if (r_dot > len2_s)      circ_hit = (r_f2 <= r2_s);
        else                          circ_hit = (r_big1 <= r_big2);
    end

endmodule

>>> rtl/segment_obstacle_collision_check_core.sv
// Segment versus obstacle collision checker.
// Input channel (i_valid / o_stall) takes command words: write a quad
// corner, write a circle, or query a segment. A word is taken at a clock
// edge with i_valid high and o_stall low. Only a query gives a result word
// on the output channel (o_valid / i_stall, field o_safe).
// Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set the
// number of active quads and circles; write them while the block is idle.
// Words pass through a 4-deep queue; writes retire one per cycle while no
// query is running. A query walks the edges of active quads through a
// pipelined edge tester fed by the two read ports of the corner memory,
// one edge per cycle, then tests each active circle in an 11-step sequence
// on two shared multipliers. Counts are clamped to 8 quads and 4 circles;
// queries run one at a time.
// Reset clears the queue, counts and result register; obstacle stores
// hold nothing defined until written. When the receiver stalls, the result
// is held and the queue keeps taking words until it fills.
module segment_obstacle_collision_check_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic [2:0]         i_slot,
    input  logic [1:0]         i_corner,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    input  logic signed [15:0] i_end_x,
    input  logic signed [15:0] i_end_y,
    input  logic [14:0]        i_radius,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_safe,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [3:0]         i_cfg_data
);

    logic [3:0]      r_active_quads;
    logic [2:0]      r_active_circles;
    soc_pkg::t_qstat qstat;
    soc_pkg::t_word  push_word, head_word;
    logic            push, pop;

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_quads   <= '0;
            r_active_circles <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                soc_pkg::CFG_ACTIVE_QUADS:   r_active_quads   <= i_cfg_data;
                soc_pkg::CFG_ACTIVE_CIRCLES: r_active_circles <= i_cfg_data[2:0];
                default:                     r_active_quads   <= r_active_quads;
            endcase
        end
    end

    soc_front u_front (
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_command (i_command),
        .i_slot    (i_slot),
        .i_corner  (i_corner),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_radius  (i_radius),
        .i_qstat   (qstat),
        .o_push    (push),
        .o_word    (push_word)
    );

    soc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .i_pop   (pop),
        .o_word  (head_word),
        .o_qstat (qstat)
    );

    soc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_qstat          (qstat),
        .i_word           (head_word),
        .o_pop            (pop),
        .i_active_quads   (r_active_quads),
        .i_active_circles (r_active_circles),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_safe           (o_safe)
    );

endmodule

>>> rtl/soc_checker.sv
module soc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_safe
);

    // A stalled result word stays
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_safe))
        else $error("result changed while stalled");

    // Reset empties the result register and the queue
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_rst_queue: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

endmodule

bind segment_obstacle_collision_check_core soc_checker u_soc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_safe  (o_safe)
);
